>>> rtl/btarb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btarb_pkg
// Shared types and constants for the budgeted memory token arbiter: the
// per-CPU row layout, operation codes and the memory request bundle.
// ----------------------------------------------------------------------------
package btarb_pkg;

    // Number of CPUs sharing the token
    localparam int CPUS   = 8;
    localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    // Owner index also encodes "no owner" as CPUS
    localparam int OWN_W  = $clog2(CPUS + 1);
    localparam int PRIO_W = 13;
    localparam int TIME_W = 64;

    localparam logic [PRIO_W-1:0] NULL_PRIO = '1;
    localparam logic [PRIO_W-1:0] DEMOTE    = PRIO_W'(CPUS);
    localparam logic [OWN_W-1:0]  NO_OWNER  = OWN_W'(CPUS);

    // Operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_REVOKE  = 2'd1;
    localparam logic [1:0] OP_UPDATE  = 2'd2;

    typedef logic [CPU_W-1:0] t_cpu_idx;

    // One memory row per CPU
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] budget;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] next_ok;
        logic [TIME_W-1:0] used;
    } t_cpu_row;

    localparam t_cpu_row ROW_RESET = '{NULL_PRIO, 64'd0, 64'd0, 64'd0, 64'd0};

    // Request from the sequencer to the row memory
    typedef struct packed {
        logic     re;
        logic     we;
        t_cpu_idx addr;
        t_cpu_row wdata;
    } t_mem_req;

endpackage
`default_nettype wire

>>> rtl/btarb_cpu_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btarb_cpu_mem
// Per-CPU state memory: one row per CPU, one read or write per cycle, read
// data registered. A row never written reads back as the reset row.
// ----------------------------------------------------------------------------
module btarb_cpu_mem (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire btarb_pkg::t_mem_req i_req,
    output btarb_pkg::t_cpu_row      o_rdata
);
    import btarb_pkg::*;

    t_cpu_row        r_mem [CPUS];
    logic [CPUS-1:0] r_valid;
    t_cpu_row        r_rd_raw;
    logic            r_rd_valid;

    // Row written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    // Storage array and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_raw   <= r_mem[i_req.addr];
            r_rd_valid <= r_valid[i_req.addr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_raw : ROW_RESET;

endmodule
`default_nettype wire

>>> rtl/btarb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btarb_ctrl
// Transaction sequencer: reads, modifies and writes back CPU rows, holds the
// token owner and priority, scans pending requests on revoke.
// ----------------------------------------------------------------------------
module btarb_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_operation,
    input  wire logic [2:0]          i_cpu_id,
    input  wire logic [11:0]         i_priority_req,
    input  wire logic [63:0]         i_wcet,
    input  wire logic [63:0]         i_now,
    output logic                     o_result_valid,
    output logic                     o_ack,
    output logic [63:0]              o_wait_time,
    output logic                     o_pause_valid,
    output logic [2:0]               o_pause_cpu,
    output logic                     o_resume_valid,
    output logic [2:0]               o_resume_cpu,
    output btarb_pkg::t_mem_req      o_mem_req,
    input  wire btarb_pkg::t_cpu_row i_mem_rdata
);
    import btarb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_SELF,
        S_EVAL,
        S_REQ_DEC,
        S_PS_RD,
        S_PS_DIFF,
        S_PS_ADD,
        S_PS_WR,
        S_RV_TAKEN,
        S_RV_REM,
        S_RV_NEXT,
        S_WR_SELF,
        S_SCAN,
        S_GRANT_CHK,
        S_GRANT_WR,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [1:0]         r_op;
    t_cpu_idx           r_cpu;
    logic [11:0]        r_prio;
    logic [TIME_W-1:0]  r_wcet;
    logic [TIME_W-1:0]  r_now;
    t_cpu_row           r_self;
    t_cpu_row           r_other;
    logic [TIME_W-1:0]  r_tmp;
    logic [OWN_W-1:0]   r_owner;
    logic [PRIO_W-1:0]  r_tok_prio;
    t_cpu_idx           r_victim;
    logic [OWN_W-1:0]   r_idx;
    t_cpu_idx           r_cmp_idx;
    logic               r_rd_pend;
    logic               r_scan_go;
    logic               r_ack;
    logic [TIME_W-1:0]  r_wait;
    logic               r_pause_valid;
    logic [2:0]         r_pause_cpu;
    logic               r_resume_valid;
    logic [2:0]         r_resume_cpu;

    logic               n_late;
    logic [OWN_W-1:0]   n_own_self;
    logic               n_bad_item;

    // Request helpers
    assign n_late     = r_now < i_mem_rdata.next_ok;
    assign n_own_self = OWN_W'(r_cpu);
    assign n_bad_item = (32'(i_cpu_id) >= CPUS) ||
                        ((i_operation != OP_REQUEST) && (i_operation != OP_REVOKE) &&
                         (i_operation != OP_UPDATE));

    // Sequencer, token registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_owner    <= NO_OWNER;
            r_tok_prio <= NULL_PRIO;
            r_rd_pend  <= 1'b0;
            r_scan_go  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op           <= i_operation;
                        r_cpu          <= t_cpu_idx'(i_cpu_id);
                        r_prio         <= i_priority_req;
                        r_wcet         <= i_wcet;
                        r_now          <= i_now;
                        r_scan_go      <= 1'b0;
                        r_ack          <= 1'b0;
                        r_wait         <= '0;
                        r_pause_valid  <= 1'b0;
                        r_pause_cpu    <= '0;
                        r_resume_valid <= 1'b0;
                        r_resume_cpu   <= '0;
                        r_state        <= n_bad_item ? S_DONE : S_RD_SELF;
                    end
                end
                S_RD_SELF: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_self.start   <= i_mem_rdata.start;
                    r_self.next_ok <= i_mem_rdata.next_ok;
                    r_self.used    <= i_mem_rdata.used;
                    if (r_op == OP_REVOKE) begin
                        r_self.prio   <= NULL_PRIO;
                        r_self.budget <= i_mem_rdata.budget;
                        r_tmp         <= r_now - i_mem_rdata.start;
                        r_state       <= (r_owner == n_own_self) ? S_RV_TAKEN : S_WR_SELF;
                    end else begin
                        // demote an early re-request and report the remaining wait
                        r_self.prio <= n_late ? (PRIO_W'(r_prio) + DEMOTE) : PRIO_W'(r_prio);
                        r_wait      <= n_late ? (i_mem_rdata.next_ok - r_now) : '0;
                        r_self.budget <= (r_op == OP_REQUEST) ? r_wcet : i_mem_rdata.budget;
                        r_state <= S_REQ_DEC;
                    end
                end
                S_REQ_DEC: begin
                    if (r_self.prio < r_tok_prio) begin
                        r_self.start <= r_now;
                        r_owner      <= n_own_self;
                        r_tok_prio   <= r_self.prio;
                        r_ack        <= 1'b1;
                        if ((r_owner != NO_OWNER) && (r_owner != n_own_self)) begin
                            r_victim      <= r_owner[CPU_W-1:0];
                            r_pause_valid <= 1'b1;
                            r_pause_cpu   <= 3'(r_owner);
                            r_state       <= S_PS_RD;
                        end else begin
                            r_state <= S_WR_SELF;
                        end
                    end else begin
                        r_ack   <= (r_owner == n_own_self);
                        r_state <= S_WR_SELF;
                    end
                end
                S_PS_RD: begin
                    r_state <= S_PS_DIFF;
                end
                S_PS_DIFF: begin
                    r_other <= i_mem_rdata;
                    r_tmp   <= r_now - i_mem_rdata.start;
                    r_state <= S_PS_ADD;
                end
                S_PS_ADD: begin
                    // freeze the preempted owner's used time
                    r_other.used <= r_other.used + r_tmp;
                    r_state      <= S_PS_WR;
                end
                S_PS_WR: begin
                    r_state <= S_WR_SELF;
                end
                S_RV_TAKEN: begin
                    r_tmp   <= r_self.used + r_tmp;
                    r_state <= S_RV_REM;
                end
                S_RV_REM: begin
                    // remaining budget, saturating at zero
                    r_tmp   <= (r_self.budget > r_tmp) ? (r_self.budget - r_tmp) : '0;
                    r_state <= S_RV_NEXT;
                end
                S_RV_NEXT: begin
                    r_self.next_ok <= r_now + r_tmp;
                    r_self.used    <= '0;
                    r_owner        <= NO_OWNER;
                    r_tok_prio     <= NULL_PRIO;
                    r_idx          <= '0;
                    r_rd_pend      <= 1'b0;
                    r_scan_go      <= 1'b1;
                    r_state        <= S_WR_SELF;
                end
                S_WR_SELF: begin
                    r_state <= r_scan_go ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    // compare the row read last cycle; lowest index wins ties
                    if (r_rd_pend && (i_mem_rdata.prio < r_tok_prio)) begin
                        r_tok_prio <= i_mem_rdata.prio;
                        r_owner    <= OWN_W'(r_cmp_idx);
                    end
                    if (r_idx < NO_OWNER) begin
                        r_cmp_idx <= r_idx[CPU_W-1:0];
                        r_rd_pend <= 1'b1;
                        r_idx     <= r_idx + OWN_W'(1);
                    end else begin
                        r_rd_pend <= 1'b0;
                        r_state   <= S_GRANT_CHK;
                    end
                end
                S_GRANT_CHK: begin
                    if (r_owner != NO_OWNER) begin
                        r_resume_valid <= 1'b1;
                        r_resume_cpu   <= 3'(r_owner);
                        r_state        <= S_GRANT_WR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_GRANT_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Memory port control
    always_comb begin
        o_mem_req       = '0;
        o_mem_req.addr  = r_cpu;
        o_mem_req.wdata = r_self;
        case (r_state)
            S_RD_SELF: begin
                o_mem_req.re = 1'b1;
            end
            S_PS_RD: begin
                o_mem_req.re   = 1'b1;
                o_mem_req.addr = r_victim;
            end
            S_PS_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = r_victim;
                o_mem_req.wdata = r_other;
            end
            S_WR_SELF: begin
                o_mem_req.we = 1'b1;
            end
            S_SCAN: begin
                o_mem_req.re   = (r_idx < NO_OWNER);
                o_mem_req.addr = r_idx[CPU_W-1:0];
            end
            S_GRANT_CHK: begin
                o_mem_req.re   = (r_owner != NO_OWNER);
                o_mem_req.addr = r_owner[CPU_W-1:0];
            end
            S_GRANT_WR: begin
                // new owner starts its access now
                o_mem_req.we          = 1'b1;
                o_mem_req.addr        = r_owner[CPU_W-1:0];
                o_mem_req.wdata       = i_mem_rdata;
                o_mem_req.wdata.start = r_now;
            end
            default: begin
                o_mem_req.re = 1'b0;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);
    assign o_ack          = r_ack;
    assign o_wait_time    = r_wait;
    assign o_pause_valid  = r_pause_valid;
    assign o_pause_cpu    = r_pause_cpu;
    assign o_resume_valid = r_resume_valid;
    assign o_resume_cpu   = r_resume_cpu;

endmodule
`default_nettype wire

>>> rtl/budgeted_memory_token_arbiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// budgeted_memory_token_arbiter_core
// Preemptive priority arbiter for one memory-access token shared by CPUs.
// ----------------------------------------------------------------------------
// Usage:
//   An operation (request, revoke or priority update) is taken when start is
//   high and busy is low. busy stays high until the result has been shown.
//   The result appears on the o_ ports for exactly one cycle, flagged by
//   o_result_valid; the receiver cannot stall it and must take it then.
//   Exactly one result follows each operation.
// Sequencing:
//   Request or update: reads and writes back the CPU row; when a previous
//   owner is preempted, its row is also read, updated and written back.
//   Revoke by the owner: also resumes a pending CPU if there is one, found by
//   a scan that reads every CPU row once from the single-port row memory.
//   Revoke by a non-owner: own row only. Invalid cpu_id or operation: straight to the result.
//   A new operation can be taken the cycle after the result strobe.
// Reset:
//   Synchronous, active low. Clears the token to no owner and marks every
//   CPU row as unwritten, so it reads as reset state; no clearing pass.
// ----------------------------------------------------------------------------
module budgeted_memory_token_arbiter_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_operation,
    input  wire logic [2:0]    i_cpu_id,
    input  wire logic [11:0]   i_priority_req,
    input  wire logic [63:0]   i_wcet,
    input  wire logic [63:0]   i_now,
    output logic               o_result_valid,
    output logic               o_ack,
    output logic [63:0]        o_wait_time,
    output logic               o_pause_valid,
    output logic [2:0]         o_pause_cpu,
    output logic               o_resume_valid,
    output logic [2:0]         o_resume_cpu
);
    import btarb_pkg::*;

    t_mem_req mem_req;
    t_cpu_row mem_rdata;

    // Transaction sequencer
    btarb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_cpu_id       (i_cpu_id),
        .i_priority_req (i_priority_req),
        .i_wcet         (i_wcet),
        .i_now          (i_now),
        .o_result_valid (o_result_valid),
        .o_ack          (o_ack),
        .o_wait_time    (o_wait_time),
        .o_pause_valid  (o_pause_valid),
        .o_pause_cpu    (o_pause_cpu),
        .o_resume_valid (o_resume_valid),
        .o_resume_cpu   (o_resume_cpu),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata)
    );

    // Per-CPU row memory
    btarb_cpu_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    // An accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Result strobe ends the transaction
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (!busy && !o_result_valid))
        else $error("block still busy after result strobe");

    // A pause only goes with the requester winning the token
    a_pause_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_pause_valid) |-> (o_ack && !o_resume_valid))
        else $error("pause without grant to the requester");

    // A resume only comes from a revoke, which never acknowledges
    a_resume_revoke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_resume_valid) |-> (!o_ack && (o_wait_time == 64'd0)))
        else $error("resume reported on a request");
`endif

endmodule
`default_nettype wire
